### rtl/core/vcs_pkg.sv
// Shared constants, payload types and controller interface types for the cosine block.
`default_nettype none

package vcs_pkg;

    // Sizing of the element stream and of the running sums.
    localparam int MAX_LENGTH = 1024;
    localparam int ELEM_W     = 16;
    localparam int NORM_W     = 2 * ELEM_W - 1 + $clog2(MAX_LENGTH);
    localparam int DOT_W      = NORM_W + 1;

    // The norm product is formed from four half-width partial products.
    localparam int PROD_W     = 2 * NORM_W;
    localparam int HALF_W     = (NORM_W + 1) / 2;
    localparam int PP_STEPS   = 4;
    localparam int PP_SEL_W   = 2;

    // Quotient bits and output format.
    localparam int Q_W        = 14;
    localparam int OUT_W      = 16;
    localparam int CNT_W      = $clog2(NORM_W);

    localparam logic signed [OUT_W-1:0] COS_ONE = 16'sd16384;

    // Partial product selectors: bit 0 picks the half of norm A, bit 1 the half of norm B.
    localparam logic [PP_SEL_W-1:0] PP_LL = 2'd0;
    localparam logic [PP_SEL_W-1:0] PP_HL = 2'd1;
    localparam logic [PP_SEL_W-1:0] PP_LH = 2'd2;
    localparam logic [PP_SEL_W-1:0] PP_HH = 2'd3;

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last_item;
    } item_t;

    typedef struct packed {
        logic signed [15:0] cosine_q14;
        logic               zero_norm;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                acc_en;
        logic                mul_step;
        logic [PP_SEL_W-1:0] pp_sel;
        logic                root_step;
        logic                div_step;
        logic                first;
        logic                res_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic norm_zero;
    } status_t;

    typedef enum logic [4:0] {
        ST_ACCUM = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ROOT  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

### rtl/core/vcs_datapath.sv
// Datapath: accumulators, norm product, square root and quotient units, result register.
`default_nettype none

module vcs_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire vcs_pkg::item_t  item,
    input  wire vcs_pkg::cmd_t   cmd,
    output vcs_pkg::status_t     status,
    output vcs_pkg::result_t     result
);
    import vcs_pkg::*;

    // Running sums.
    logic [DOT_W-1:0]  dot_reg,    dot_next;
    logic [NORM_W-1:0] norm_a_reg, norm_a_next;
    logic [NORM_W-1:0] norm_b_reg, norm_b_next;

    logic signed [ELEM_W-1:0]   a_s, b_s;
    logic signed [2*ELEM_W-1:0] ab_prod, aa_prod, bb_prod;

    // Norm product, later shifted out two bits at a time into the root unit.
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [HALF_W-1:0]   x_op, y_op;
    logic [2*HALF_W-1:0] pp;
    logic [PROD_W-1:0]   pp_ext, pp_shifted;

    // Sign and magnitude of the dot product.
    logic             sign_reg, sign_next;
    logic [DOT_W-1:0] mag_reg,  mag_next;

    // Square root unit.
    logic [NORM_W:0]   sq_rem_reg, sq_rem_next, sq_rem_in;
    logic [NORM_W-1:0] root_reg,   root_next,   root_in;
    logic [NORM_W+2:0] sq_shift, sq_trial, sq_diff;
    logic              sq_ge;

    // Quotient unit.
    logic [DOT_W-1:0] div_rem_reg, div_rem_next, div_in;
    logic [DOT_W:0]   div_shift, div_den, div_diff;
    logic             div_ge;
    logic [Q_W-1:0]   quot_reg, quot_next, quot_in;

    // Result register.
    logic             sat;
    logic [OUT_W-1:0] mag_res;
    result_t          result_reg, result_next;

    // Element products, sign-extended from the element width.
    assign a_s     = item.elem_a[ELEM_W-1:0];
    assign b_s     = item.elem_b[ELEM_W-1:0];
    assign ab_prod = a_s * b_s;
    assign aa_prod = a_s * a_s;
    assign bb_prod = b_s * b_s;

    // Sum update: cleared on result load, else accumulated, wrapping at the sum widths.
    always_comb
    begin
        dot_next    = dot_reg;
        norm_a_next = norm_a_reg;
        norm_b_next = norm_b_reg;
        if (cmd.res_load)
        begin
            dot_next    = '0;
            norm_a_next = '0;
            norm_b_next = '0;
        end
        else if (cmd.acc_en)
        begin
            dot_next    = dot_reg + DOT_W'(ab_prod);
            norm_a_next = norm_a_reg + NORM_W'($unsigned(aa_prod));
            norm_b_next = norm_b_reg + NORM_W'($unsigned(bb_prod));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg    <= '0;
            norm_a_reg <= '0;
            norm_b_reg <= '0;
        end
        else
        begin
            dot_reg    <= dot_next;
            norm_a_reg <= norm_a_next;
            norm_b_reg <= norm_b_next;
        end
    end

    assign status.norm_zero = (norm_a_reg == '0) || (norm_b_reg == '0);

    // Partial product operand selection and alignment.
    assign x_op   = cmd.pp_sel[0] ? HALF_W'(norm_a_reg[NORM_W-1:HALF_W])
                                  : norm_a_reg[HALF_W-1:0];
    assign y_op   = cmd.pp_sel[1] ? HALF_W'(norm_b_reg[NORM_W-1:HALF_W])
                                  : norm_b_reg[HALF_W-1:0];
    assign pp     = x_op * y_op;
    assign pp_ext = PROD_W'(pp);

    always_comb
    begin
        case (cmd.pp_sel) inside
            PP_LL:        pp_shifted = pp_ext;
            PP_HL, PP_LH: pp_shifted = pp_ext << HALF_W;
            PP_HH:        pp_shifted = pp_ext << (2 * HALF_W);
            default:      pp_shifted = pp_ext;
        endcase
    end

    // Product accumulation, dot sign/magnitude capture, then a two-bit shift per root step.
    always_comb
    begin
        prod_next = prod_reg;
        sign_next = sign_reg;
        mag_next  = mag_reg;
        if (cmd.mul_step)
        begin
            prod_next = (cmd.first ? '0 : prod_reg) + pp_shifted;
            if (cmd.first)
            begin
                sign_next = dot_reg[DOT_W-1];
                mag_next  = dot_reg[DOT_W-1] ? (~dot_reg + DOT_W'(1)) : dot_reg;
            end
        end
        else if (cmd.root_step)
        begin
            prod_next = prod_reg << 2;
        end
    end

    // One result bit of the integer square root per step.
    assign sq_rem_in = cmd.first ? '0 : sq_rem_reg;
    assign root_in   = cmd.first ? '0 : root_reg;
    assign sq_shift  = {sq_rem_in, prod_reg[PROD_W-1 -: 2]};
    assign sq_trial  = {1'b0, root_in, 2'b01};
    assign sq_ge     = sq_shift >= sq_trial;
    assign sq_diff   = sq_shift - sq_trial;

    always_comb
    begin
        sq_rem_next = sq_rem_reg;
        root_next   = root_reg;
        if (cmd.root_step)
        begin
            sq_rem_next = sq_ge ? sq_diff[NORM_W:0] : sq_shift[NORM_W:0];
            root_next   = {root_in[NORM_W-2:0], sq_ge};
        end
    end

    // One quotient bit of magnitude / root per step.
    assign div_in    = cmd.first ? mag_reg : div_rem_reg;
    assign quot_in   = cmd.first ? '0 : quot_reg;
    assign div_shift = {div_in, 1'b0};
    assign div_den   = (DOT_W + 1)'(root_reg);
    assign div_ge    = div_shift >= div_den;
    assign div_diff  = div_shift - div_den;

    always_comb
    begin
        div_rem_next = div_rem_reg;
        quot_next    = quot_reg;
        if (cmd.div_step)
        begin
            div_rem_next = div_ge ? div_diff[DOT_W-1:0] : div_shift[DOT_W-1:0];
            quot_next    = {quot_in[Q_W-2:0], div_ge};
        end
    end

    // Final result: zero-norm case, saturation when the magnitude reaches the root.
    assign sat     = mag_reg >= DOT_W'(root_reg);
    assign mag_res = sat ? COS_ONE : OUT_W'(quot_reg);

    always_comb
    begin
        result_next = result_reg;
        if (cmd.res_load)
        begin
            if (status.norm_zero)
            begin
                result_next.cosine_q14 = '0;
                result_next.zero_norm  = 1'b1;
            end
            else
            begin
                result_next.cosine_q14 = sign_reg ? -mag_res : mag_res;
                result_next.zero_norm  = 1'b0;
            end
        end
    end

    // Working registers carry payload only.
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        sign_reg    <= sign_next;
        mag_reg     <= mag_next;
        sq_rem_reg  <= sq_rem_next;
        root_reg    <= root_next;
        div_rem_reg <= div_rem_next;
        quot_reg    <= quot_next;
        result_reg  <= result_next;
    end

    assign result = result_reg;

    // The sums are empty after every result.
    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> (dot_reg == '0 && norm_a_reg == '0 && norm_b_reg == '0))
        else $error("sums not cleared after result");

    // Division only runs with nonzero norms, so the root is at least one.
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> root_reg != '0)
        else $error("division by a zero root");

    // A loaded result stays within plus or minus one.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> (result.zero_norm ||
            (result.cosine_q14 <= COS_ONE && result.cosine_q14 >= -COS_ONE)))
        else $error("cosine out of range");

endmodule

`default_nettype wire

### rtl/core/vcs_ctrl.sv
// Controller: sequences accumulation, norm product, root, division and result hand-off.
`default_nettype none

module vcs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_last,
    output logic                   item_stall,
    output logic                   result_valid,
    input  wire logic              result_stall,
    input  wire vcs_pkg::status_t  status,
    output vcs_pkg::cmd_t          cmd
);
    import vcs_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Requests are taken only while accumulating.
    assign item_stall   = (state_reg != ST_ACCUM);
    assign result_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (item_valid)
                begin
                    cmd.acc_en = 1'b1;
                    if (item_last)
                    begin
                        state_next = ST_MUL;
                        cnt_next   = '0;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.first    = (cnt_reg == '0);
                cmd.pp_sel   = cnt_reg[PP_SEL_W-1:0];
                if (cnt_reg == CNT_W'(PP_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = status.norm_zero ? ST_DONE : ST_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cmd.first     = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(NORM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.first    = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
                cnt_next   = '0;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A closing request always starts the norm product.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item_last) |=> state_reg == ST_MUL)
        else $error("last request did not start the computation");

    // The step counter stays inside the root length.
    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROOT |-> cnt_reg < CNT_W'(NORM_W))
        else $error("root step counter overran");

    // A result appears only as the hand-off state completes.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result without completed computation");

endmodule

`default_nettype wire

### rtl/core/vector_cosine_similarity_top.sv
// Top level of the streaming vector cosine similarity block.
//
//   Channel  Signals                            Carries
//   item     item_valid, item_stall, item       one element pair and the last mark
//   result   result_valid, result_stall, result cosine in Q1.14 and zero-norm flag
//
// Element pairs are taken one per cycle while accumulating.
// After the last pair: the norm product from four partial products, one root step
// per root bit, one quotient step per quotient bit, then the result load. A zero
// norm skips the root and quotient steps. The root and quotient units run in turn.
// Reset clears the sums, the controller and the result valid.
// The item channel stalls from the last pair until the result is loaded; a stalled
// result holds the block in its load state while it waits.
`default_nettype none

module vector_cosine_similarity_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire vcs_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output vcs_pkg::result_t       result
);
    import vcs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    vcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_last    (item.last_item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic.
    vcs_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire
